// ===== src/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define FCCR_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// next-cycle implication
`define FCCR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`else

`define FCCR_ASSERT_SAME(label, clk, rst, ante, cons)
`define FCCR_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== src/fccr_pkg.sv =====
`default_nettype none

package fccr_pkg;

   localparam int unsigned MAX_CLUSTER_SECTORS = 64;
   // wide enough to hold the sector count itself
   localparam int unsigned SECT_W = $clog2(MAX_CLUSTER_SECTORS + 1);
   localparam int unsigned OFS_W = 16 + SECT_W;

   localparam logic [15:0] END_OF_CHAIN = 16'hFFF8;
   localparam logic [15:0] FIRST_CLUSTER = 16'd2;
   localparam logic [9:0] SECTOR_BYTES = 10'd512;
   localparam int unsigned DIR_ENTRY_BYTES = 32;
   localparam int unsigned ROOT_ENTRIES_PER_SECTOR = 512 / DIR_ENTRY_BYTES;
   // bytes of one fat16 entry
   localparam int unsigned FAT_ENTRY_BYTES = 2;
   localparam int unsigned FAT_SHIFT = $clog2(512 / FAT_ENTRY_BYTES);

   typedef enum logic [2:0] {
      REG_VOLUME_START     = 3'd0,
      REG_RESERVED_SECTORS = 3'd1,
      REG_FAT_COPIES       = 3'd2,
      REG_SECTORS_EACH_FAT = 3'd3,
      REG_ROOT_ENTRIES     = 3'd4,
      REG_CLUSTER_SECTORS  = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [31:0] volume_start_sector;
      logic [15:0] reserved_sector_count;
      logic [7:0]  fat_copies;
      logic [15:0] sectors_each_fat;
      logic [15:0] root_entry_count;
      logic [6:0]  cluster_sectors;
   } cfg_type;

   typedef enum logic [1:0] {
      MODE_EMPTY   = 2'd0,
      MODE_INVALID = 2'd1,
      MODE_WALK    = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_CALC = 2'd1,
      ST_LOAD = 2'd2,
      ST_EMIT = 2'd3
   } state_type;

   typedef struct packed {
      logic capture;
      logic calc;
      logic load;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic done;
   } status_type;

endpackage

`default_nettype wire

// ===== src/fccr_csr.sv =====
`default_nettype none

module fccr_csr (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [4:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready,
   output fccr_pkg::cfg_type   cfg,
   output logic [23:0]         fat_area
);

   fccr_pkg::cfg_type cfg_ff;
   logic [23:0] fat_area_ff;
   logic wr_en;
   fccr_pkg::reg_index_type idx;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite;
   assign idx = fccr_pkg::reg_index_type'(csr_paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.volume_start_sector <= 32'd0;
         cfg_ff.reserved_sector_count <= 16'd1;
         cfg_ff.fat_copies <= 8'd2;
         cfg_ff.sectors_each_fat <= 16'd0;
         cfg_ff.root_entry_count <= 16'd512;
         cfg_ff.cluster_sectors <= 7'd1;
      end else if (wr_en) begin
         unique case (idx)
            fccr_pkg::REG_VOLUME_START: begin
               cfg_ff.volume_start_sector <= csr_pwdata;
            end
            fccr_pkg::REG_RESERVED_SECTORS: begin
               cfg_ff.reserved_sector_count <= csr_pwdata[15:0];
            end
            fccr_pkg::REG_FAT_COPIES: begin
               cfg_ff.fat_copies <= csr_pwdata[7:0];
            end
            fccr_pkg::REG_SECTORS_EACH_FAT: begin
               cfg_ff.sectors_each_fat <= csr_pwdata[15:0];
            end
            fccr_pkg::REG_ROOT_ENTRIES: begin
               cfg_ff.root_entry_count <= csr_pwdata[15:0];
            end
            fccr_pkg::REG_CLUSTER_SECTORS: begin
               cfg_ff.cluster_sectors <= csr_pwdata[6:0];
            end
            default: begin
            end
         endcase
      end
   end

   // size of all fat copies, kept ready for the data area base
   always_ff @(posedge clock) begin
      fat_area_ff <= 24'(cfg_ff.fat_copies * cfg_ff.sectors_each_fat);
   end

   always_comb begin
      unique case (idx)
         fccr_pkg::REG_VOLUME_START:     csr_prdata = cfg_ff.volume_start_sector;
         fccr_pkg::REG_RESERVED_SECTORS: csr_prdata = {16'd0, cfg_ff.reserved_sector_count};
         fccr_pkg::REG_FAT_COPIES:       csr_prdata = {24'd0, cfg_ff.fat_copies};
         fccr_pkg::REG_SECTORS_EACH_FAT: csr_prdata = {16'd0, cfg_ff.sectors_each_fat};
         fccr_pkg::REG_ROOT_ENTRIES:     csr_prdata = {16'd0, cfg_ff.root_entry_count};
         fccr_pkg::REG_CLUSTER_SECTORS:  csr_prdata = {25'd0, cfg_ff.cluster_sectors};
         default:                        csr_prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;
   assign fat_area = fat_area_ff;

endmodule

`default_nettype wire

// ===== src/fccr_ctrl.sv =====
`default_nettype none

`include "assert_macros.svh"

module fccr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output fccr_pkg::cmd_type     cmd,
   input  fccr_pkg::status_type  status
);

   fccr_pkg::state_type state_ff;
   fccr_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fccr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         fccr_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in = fccr_pkg::ST_CALC;
            end
         end
         fccr_pkg::ST_CALC: begin
            cmd.calc = 1'b1;
            state_in = fccr_pkg::ST_LOAD;
         end
         fccr_pkg::ST_LOAD: begin
            cmd.load = 1'b1;
            state_in = fccr_pkg::ST_EMIT;
         end
         fccr_pkg::ST_EMIT: begin
            // one result per cycle while the output register has room
            cmd.emit = status.out_free;
            if (status.out_free && status.done) begin
               state_in = fccr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fccr_pkg::ST_IDLE;
         end
      endcase
   end

   `FCCR_ASSERT_NEXT(a_done_frees_input, clock, reset, cmd.emit && status.done, !req_stall)
   `FCCR_ASSERT_NEXT(a_hold_while_full, clock, reset,
      state_ff == fccr_pkg::ST_EMIT && !status.out_free, state_ff == fccr_pkg::ST_EMIT)

endmodule

`default_nettype wire

// ===== src/fccr_dpath.sv =====
`default_nettype none

`include "assert_macros.svh"

module fccr_dpath (
   input  logic                  clock,
   input  logic                  reset,
   input  fccr_pkg::cmd_type     cmd,
   output fccr_pkg::status_type  status,
   input  fccr_pkg::cfg_type     cfg,
   input  logic [23:0]           fat_area,
   input  logic                  req_action,
   input  logic [15:0]           req_cluster_number,
   input  logic [31:0]           req_file_size,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_read_valid,
   output logic [31:0]           rsp_data_lba,
   output logic [9:0]            rsp_byte_count,
   output logic                  rsp_file_end,
   output logic                  rsp_fat_request,
   output logic [31:0]           rsp_fat_lba,
   output logic [8:0]            rsp_entry_offset,
   output logic                  rsp_last
);

   localparam int unsigned SW = fccr_pkg::SECT_W;
   localparam int unsigned OW = fccr_pkg::OFS_W;

   // request and walk state
   logic              action_ff;
   logic [15:0]       cluster_ff;
   logic [31:0]       bytes_left_ff;
   logic              awaiting_ff;
   fccr_pkg::mode_type mode_ff;
   logic [SW-1:0]     per_ff;
   logic [SW-1:0]     remain_ff;
   logic [OW-1:0]     offset_ff;
   logic [31:0]       base_ff;
   logic [31:0]       fat_lba_ff;
   logic [31:0]       lba_ff;

   // output register
   logic              rsp_valid_ff;
   logic              rsp_read_valid_ff;
   logic [31:0]       rsp_data_lba_ff;
   logic [9:0]        rsp_byte_count_ff;
   logic              rsp_file_end_ff;
   logic              rsp_fat_request_ff;
   logic [31:0]       rsp_fat_lba_ff;
   logic [8:0]        rsp_entry_offset_ff;
   logic              rsp_last_ff;

   // result being formed this cycle
   logic [9:0]        cnt;
   logic [31:0]       left_after;
   logic              res_read_valid;
   logic [9:0]        res_byte_count;
   logic              res_file_end;
   logic              res_fat_request;
   logic              res_last;
   logic              res_done;
   logic              walk_awaiting;
   logic [31:0]       walk_left;

   logic [SW-1:0]     per_cfg;
   logic              cluster_ok;

   assign per_cfg = (cfg.cluster_sectors > 7'(fccr_pkg::MAX_CLUSTER_SECTORS))
                    ? SW'(fccr_pkg::MAX_CLUSTER_SECTORS) : SW'(cfg.cluster_sectors);
   assign cluster_ok = (cluster_ff >= fccr_pkg::FIRST_CLUSTER)
                       && (cluster_ff < fccr_pkg::END_OF_CHAIN);

   assign cnt = (bytes_left_ff > 32'(fccr_pkg::SECTOR_BYTES))
                ? fccr_pkg::SECTOR_BYTES : bytes_left_ff[9:0];
   assign left_after = bytes_left_ff - 32'(cnt);

   always_comb begin
      res_read_valid = 1'b0;
      res_byte_count = 10'd0;
      res_file_end = 1'b0;
      res_fat_request = 1'b0;
      res_last = 1'b0;
      res_done = 1'b0;
      walk_awaiting = awaiting_ff;
      walk_left = bytes_left_ff;
      unique case (mode_ff)
         fccr_pkg::MODE_EMPTY: begin
            res_last = 1'b1;
            res_done = 1'b1;
         end
         fccr_pkg::MODE_INVALID: begin
            res_file_end = 1'b1;
            res_last = 1'b1;
            res_done = 1'b1;
            walk_awaiting = 1'b0;
            walk_left = 32'd0;
         end
         fccr_pkg::MODE_WALK: begin
            if (remain_ff == '0) begin
               // empty cluster: only the fat lookup
               res_fat_request = 1'b1;
               res_last = 1'b1;
               res_done = 1'b1;
               walk_awaiting = 1'b1;
            end else begin
               res_read_valid = 1'b1;
               res_byte_count = cnt;
               walk_left = left_after;
               if (left_after == 32'd0) begin
                  res_file_end = 1'b1;
                  res_last = 1'b1;
                  res_done = 1'b1;
                  walk_awaiting = 1'b0;
               end else if (remain_ff == SW'(1)) begin
                  res_fat_request = 1'b1;
                  res_last = 1'b1;
                  res_done = 1'b1;
                  walk_awaiting = 1'b1;
               end
            end
         end
         default: begin
            res_last = 1'b1;
            res_done = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff <= req_action;
         cluster_ff <= req_cluster_number;
      end
      if (cmd.calc) begin
         priority if (action_ff && !awaiting_ff) begin
            mode_ff <= fccr_pkg::MODE_EMPTY;
         end else if (!cluster_ok) begin
            mode_ff <= fccr_pkg::MODE_INVALID;
         end else begin
            mode_ff <= fccr_pkg::MODE_WALK;
         end
         per_ff <= per_cfg;
         offset_ff <= OW'((cluster_ff - fccr_pkg::FIRST_CLUSTER) * per_cfg);
         base_ff <= cfg.volume_start_sector + 32'(cfg.reserved_sector_count)
                    + 32'(fat_area)
                    + 32'(cfg.root_entry_count / fccr_pkg::ROOT_ENTRIES_PER_SECTOR);
         fat_lba_ff <= cfg.volume_start_sector + 32'(cfg.reserved_sector_count)
                       + 32'(cluster_ff >> fccr_pkg::FAT_SHIFT);
      end
      if (cmd.load) begin
         lba_ff <= base_ff + 32'(offset_ff);
         remain_ff <= per_ff;
      end else if (cmd.emit) begin
         lba_ff <= lba_ff + 32'd1;
         remain_ff <= remain_ff - SW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff <= 32'd0;
         awaiting_ff <= 1'b0;
      end else if (cmd.capture) begin
         if (!req_action) begin
            bytes_left_ff <= req_file_size;
         end
      end else if (cmd.emit) begin
         bytes_left_ff <= walk_left;
         awaiting_ff <= walk_awaiting;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_read_valid_ff <= res_read_valid;
         rsp_data_lba_ff <= res_read_valid ? lba_ff : 32'd0;
         rsp_byte_count_ff <= res_byte_count;
         rsp_file_end_ff <= res_file_end;
         rsp_fat_request_ff <= res_fat_request;
         rsp_fat_lba_ff <= res_fat_request ? fat_lba_ff : 32'd0;
         // entry offset is the low cluster bits times two
         rsp_entry_offset_ff <= res_fat_request ? {cluster_ff[7:0], 1'b0} : 9'd0;
         rsp_last_ff <= res_last;
      end
   end

   assign status.out_free = !rsp_valid_ff || !rsp_stall;
   assign status.done = res_done;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_read_valid = rsp_read_valid_ff;
   assign rsp_data_lba = rsp_data_lba_ff;
   assign rsp_byte_count = rsp_byte_count_ff;
   assign rsp_file_end = rsp_file_end_ff;
   assign rsp_fat_request = rsp_fat_request_ff;
   assign rsp_fat_lba = rsp_fat_lba_ff;
   assign rsp_entry_offset = rsp_entry_offset_ff;
   assign rsp_last = rsp_last_ff;

   `FCCR_ASSERT_SAME(a_emit_needs_room, clock, reset, cmd.emit, status.out_free)
   `FCCR_ASSERT_SAME(a_end_excludes_fat, clock, reset, rsp_valid_ff,
      !(rsp_file_end_ff && rsp_fat_request_ff))
   `FCCR_ASSERT_SAME(a_no_read_no_count, clock, reset, rsp_valid_ff && !rsp_read_valid_ff,
      rsp_byte_count_ff == 10'd0 && rsp_data_lba_ff == 32'd0)

endmodule

`default_nettype wire

// ===== src/fat16_cluster_chain_reader_unit.sv =====
// channel   direction  handshake            payload
// req       in         req_valid/req_stall  action, cluster_number, file_size
// rsp       out        rsp_valid/rsp_stall  read_valid, data_lba, byte_count, file_end,
//                                           fat_request, fat_lba, entry_offset, last
// csr       in         apb psel/penable     six volume geometry registers
//
// a request gives n results (1 to 64): the calc and load states form the sector base
// and fat address, then the emit state puts one result a cycle into the
// output register, which loads only when empty or being taken.
// a stalled rsp holds the walk; req_stall is high from acceptance until the
// final result is loaded, so the next request overlaps the waiting result.
// synchronous reset restores register defaults and drops any pending entry.
`default_nettype none

module fat16_cluster_chain_reader_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [15:0] req_cluster_number,
   input  logic [31:0] req_file_size,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_read_valid,
   output logic [31:0] rsp_data_lba,
   output logic [9:0]  rsp_byte_count,
   output logic        rsp_file_end,
   output logic        rsp_fat_request,
   output logic [31:0] rsp_fat_lba,
   output logic [8:0]  rsp_entry_offset,
   output logic        rsp_last,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   fccr_pkg::cfg_type    cfg;
   fccr_pkg::cmd_type    cmd;
   fccr_pkg::status_type status;
   logic [23:0]          fat_area;

   fccr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg),
      .fat_area    (fat_area)
   );

   fccr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .status    (status)
   );

   fccr_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .cfg                (cfg),
      .fat_area           (fat_area),
      .req_action         (req_action),
      .req_cluster_number (req_cluster_number),
      .req_file_size      (req_file_size),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_read_valid     (rsp_read_valid),
      .rsp_data_lba       (rsp_data_lba),
      .rsp_byte_count     (rsp_byte_count),
      .rsp_file_end       (rsp_file_end),
      .rsp_fat_request    (rsp_fat_request),
      .rsp_fat_lba        (rsp_fat_lba),
      .rsp_entry_offset   (rsp_entry_offset),
      .rsp_last           (rsp_last)
   );

endmodule

`default_nettype wire

// ===== sim/fat16_cluster_chain_reader_unit_test.sv =====
`default_nettype none

module fat16_cluster_chain_reader_unit_test;

   localparam logic ACT_START = 1'b0;
   localparam logic ACT_NEXT  = 1'b1;
   localparam int   CYCLE_LIMIT = 1_000_000;
   localparam int   ITEMS_PER_PHASE = 31;

   typedef struct packed {
      logic        read_valid;
      logic [31:0] data_lba;
      logic [9:0]  byte_count;
      logic        file_end;
      logic        fat_request;
      logic [31:0] fat_lba;
      logic [8:0]  entry_offset;
      logic        last;
   } chain_result_type;

   typedef struct {
      logic                    is_cfg;
      fccr_pkg::reg_index_type reg_idx;
      logic [31:0]             reg_val;
      logic                    action;
      logic [15:0]             cluster;
      logic [31:0]             size;
      logic                    typed;
      chain_result_type        typed_res;
   } dir_row_type;

   localparam chain_result_type RES_IDLE_NEXT =
      '{1'b0, 32'd0, 10'd0, 1'b0, 1'b0, 32'd0, 9'd0, 1'b1};
   localparam chain_result_type RES_CHAIN_END =
      '{1'b0, 32'd0, 10'd0, 1'b1, 1'b0, 32'd0, 9'd0, 1'b1};
   // first sector of cluster 2 with the default geometry: 0 + 1 + 2*0 + 512/16
   localparam chain_result_type RES_EMPTY_FILE =
      '{1'b1, 32'd33, 10'd0, 1'b1, 1'b0, 32'd0, 9'd0, 1'b1};

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_action;
   logic [15:0] req_cluster_number;
   logic [31:0] req_file_size;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_read_valid;
   logic [31:0] rsp_data_lba;
   logic [9:0]  rsp_byte_count;
   logic        rsp_file_end;
   logic        rsp_fat_request;
   logic [31:0] rsp_fat_lba;
   logic [8:0]  rsp_entry_offset;
   logic        rsp_last;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [4:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   fat16_cluster_chain_reader_unit u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_cluster_number (req_cluster_number),
      .req_file_size      (req_file_size),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_read_valid     (rsp_read_valid),
      .rsp_data_lba       (rsp_data_lba),
      .rsp_byte_count     (rsp_byte_count),
      .rsp_file_end       (rsp_file_end),
      .rsp_fat_request    (rsp_fat_request),
      .rsp_fat_lba        (rsp_fat_lba),
      .rsp_entry_offset   (rsp_entry_offset),
      .rsp_last           (rsp_last),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   always #5 clock = ~clock;

   // volume geometry and walk state as the block should hold them
   fccr_pkg::cfg_type geom;
   logic [15:0]       chain_cluster;
   logic [31:0]       chain_bytes_left;
   logic              chain_pending;
   chain_result_type  step_walk[$];
   chain_result_type  walk_results_q[$];

   dir_row_type dir_tab[$];
   int          send_idle_pct = 16;
   int          rcv_stall_pct = 85;
   int          n_errors = 0;
   int          cycles = 0;

   function automatic void walk_cluster(input logic [15:0] c);
      chain_result_type r;
      logic [6:0]       per;
      logic [31:0]      data_start;
      logic [31:0]      first;
      logic [31:0]      cnt;
      r = '0;
      if (c < fccr_pkg::FIRST_CLUSTER || c >= fccr_pkg::END_OF_CHAIN) begin
         chain_pending = 1'b0;
         chain_bytes_left = '0;
         r.file_end = 1'b1;
         r.last = 1'b1;
         step_walk.push_back(r);
         return;
      end
      per = geom.cluster_sectors;
      if (per > fccr_pkg::MAX_CLUSTER_SECTORS) per = 7'(fccr_pkg::MAX_CLUSTER_SECTORS);
      data_start = geom.volume_start_sector + 32'(geom.reserved_sector_count)
                 + 32'(geom.fat_copies) * 32'(geom.sectors_each_fat)
                 + 32'(geom.root_entry_count / 16);
      first = data_start + (32'(c) - 32'd2) * 32'(per);
      for (int s = 0; s < int'(per); s++) begin
         cnt = (chain_bytes_left > 32'd512) ? 32'd512 : chain_bytes_left;
         chain_bytes_left = chain_bytes_left - cnt;
         r = '0;
         r.read_valid = 1'b1;
         r.data_lba = first + 32'(s);
         r.byte_count = cnt[9:0];
         if (chain_bytes_left == 0) begin
            r.file_end = 1'b1;
            r.last = 1'b1;
            chain_pending = 1'b0;
            step_walk.push_back(r);
            return;
         end
         step_walk.push_back(r);
      end
      // the cluster is used up with bytes left over: ask for its fat entry
      if (step_walk.size() == 0) r = '0;
      else r = step_walk.pop_back();
      r.fat_request = 1'b1;
      r.fat_lba = geom.volume_start_sector + 32'(geom.reserved_sector_count) + 32'(c >> 8);
      r.entry_offset = {c[7:0], 1'b0};
      r.last = 1'b1;
      step_walk.push_back(r);
      chain_cluster = c;
      chain_pending = 1'b1;
   endfunction

   function automatic void predict_walk(input logic act, input logic [15:0] cl,
                                        input logic [31:0] sz);
      chain_result_type r;
      step_walk.delete();
      if (act == ACT_START) begin
         chain_bytes_left = sz;
         chain_cluster = cl;
         walk_cluster(cl);
      end else if (!chain_pending) begin
         r = '0;
         r.last = 1'b1;
         step_walk.push_back(r);
      end else begin
         walk_cluster(cl);
      end
   endfunction

   function automatic dir_row_type item_row(input logic act, input logic [15:0] cl,
                                            input logic [31:0] sz);
      dir_row_type d;
      d = '{1'b0, fccr_pkg::REG_VOLUME_START, 32'd0, act, cl, sz, 1'b0, '0};
      return d;
   endfunction

   function automatic dir_row_type typed_row(input logic act, input logic [15:0] cl,
                                             input logic [31:0] sz,
                                             input chain_result_type res);
      dir_row_type d;
      d = '{1'b0, fccr_pkg::REG_VOLUME_START, 32'd0, act, cl, sz, 1'b1, res};
      return d;
   endfunction

   function automatic dir_row_type cfg_row(input fccr_pkg::reg_index_type idx,
                                           input logic [31:0] val);
      dir_row_type d;
      d = '{1'b1, idx, val, ACT_START, 16'd0, 32'd0, 1'b0, '0};
      return d;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         n_errors++;
      end
   endtask

   task automatic write_reg(input fccr_pkg::reg_index_type idx, input logic [31:0] val);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         fccr_pkg::REG_VOLUME_START:     geom.volume_start_sector = val;
         fccr_pkg::REG_RESERVED_SECTORS: geom.reserved_sector_count = val[15:0];
         fccr_pkg::REG_FAT_COPIES:       geom.fat_copies = val[7:0];
         fccr_pkg::REG_SECTORS_EACH_FAT: geom.sectors_each_fat = val[15:0];
         fccr_pkg::REG_ROOT_ENTRIES:     geom.root_entry_count = val[15:0];
         fccr_pkg::REG_CLUSTER_SECTORS:  geom.cluster_sectors = val[6:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (walk_results_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic send_request(input logic act, input logic [15:0] cl, input logic [31:0] sz,
                               input logic typed, input chain_result_type typed_res);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_cluster_number <= cl;
      req_file_size <= sz;
      do @(posedge clock); while (req_stall);
      predict_walk(act, cl, sz);
      if (typed) walk_results_q.push_back(typed_res);
      else foreach (step_walk[k]) walk_results_q.push_back(step_walk[k]);
   endtask

   task automatic random_geometry();
      logic [31:0] v;
      case ($urandom_range(2))
         0: v = 32'd0;
         1: v = 32'hFFFF_FFFF;
         default: v = $urandom;
      endcase
      write_reg(fccr_pkg::REG_VOLUME_START, v);
      case ($urandom_range(2))
         0: v = 32'd0;
         1: v = 32'hFFFF;
         default: v = $urandom_range(16'hFFFF);
      endcase
      write_reg(fccr_pkg::REG_RESERVED_SECTORS, v);
      case ($urandom_range(2))
         0: v = 32'd1;
         1: v = 32'd255;
         default: v = $urandom_range(255, 1);
      endcase
      write_reg(fccr_pkg::REG_FAT_COPIES, v);
      case ($urandom_range(2))
         0: v = 32'd0;
         1: v = 32'hFFFF;
         default: v = $urandom_range(16'hFFFF);
      endcase
      write_reg(fccr_pkg::REG_SECTORS_EACH_FAT, v);
      case ($urandom_range(2))
         0: v = 32'd0;
         1: v = 32'hFFFF;
         default: v = $urandom_range(16'hFFFF);
      endcase
      write_reg(fccr_pkg::REG_ROOT_ENTRIES, v);
      // mostly small clusters so chains run several links
      case ($urandom_range(9))
         0: v = 32'd0;
         1: v = 32'd64;
         2: v = $urandom_range(127, 65);
         default: v = $urandom_range(8, 1);
      endcase
      write_reg(fccr_pkg::REG_CLUSTER_SECTORS, v);
   endtask

   task automatic random_request();
      logic [15:0] cl;
      logic [31:0] sz;
      int          per;
      logic        act;
      per = (geom.cluster_sectors > fccr_pkg::MAX_CLUSTER_SECTORS)
            ? fccr_pkg::MAX_CLUSTER_SECTORS : int'(geom.cluster_sectors);
      if (per == 0) per = 1;
      sz = 32'd0;
      if (chain_pending && $urandom_range(9) < 8) begin
         // follow the chain, sometimes hitting its end
         act = ACT_NEXT;
         case ($urandom_range(19))
            0: cl = 16'hFFFF;
            1: cl = 16'($urandom_range(16'hFFFF, fccr_pkg::END_OF_CHAIN));
            2: cl = 16'($urandom_range(1));
            default: cl = 16'($urandom_range(16'hFFF7, 2));
         endcase
         sz = $urandom;
      end else if ($urandom_range(9) == 0) begin
         act = ACT_NEXT;
         cl = 16'($urandom);
         sz = $urandom;
      end else begin
         act = ACT_START;
         if ($urandom_range(9) == 0) cl = 16'($urandom);
         else cl = 16'($urandom_range(16'hFFF7, 2));
         case ($urandom_range(9))
            0: sz = 32'd0;
            1: sz = $urandom;
            2: sz = 32'hFFFF_FFFF;
            default: sz = $urandom_range(3 * per * 512);
         endcase
      end
      send_request(act, cl, sz, 1'b0, '0);
   endtask

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rcv_stall_pct);
   end

   always @(posedge clock) begin : result_check
      chain_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (walk_results_q.size() == 0) begin
            $error("result with nothing expected");
            n_errors++;
         end else begin
            want = walk_results_q.pop_front();
            check_field("read_valid", 32'(want.read_valid), 32'(rsp_read_valid));
            check_field("data_lba", want.data_lba, rsp_data_lba);
            check_field("byte_count", 32'(want.byte_count), 32'(rsp_byte_count));
            check_field("file_end", 32'(want.file_end), 32'(rsp_file_end));
            check_field("fat_request", 32'(want.fat_request), 32'(rsp_fat_request));
            check_field("fat_lba", want.fat_lba, rsp_fat_lba);
            check_field("entry_offset", 32'(want.entry_offset), 32'(rsp_entry_offset));
            check_field("last", 32'(want.last), 32'(rsp_last));
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("fat16_cluster_chain_reader_unit_test failed");
         $finish;
      end
   end

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_action <= ACT_START;
      req_cluster_number <= '0;
      req_file_size <= '0;
      rsp_stall <= 1'b0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      geom = '{32'd0, 16'd1, 8'd2, 16'd0, 16'd512, 7'd1};
      chain_cluster = '0;
      chain_bytes_left = '0;
      chain_pending = 1'b0;

      dir_tab.push_back(typed_row(ACT_NEXT, 16'h1234, 32'd0, RES_IDLE_NEXT));
      dir_tab.push_back(typed_row(ACT_START, 16'h0000, 32'd100, RES_CHAIN_END));
      dir_tab.push_back(typed_row(ACT_START, 16'h0001, 32'd100, RES_CHAIN_END));
      dir_tab.push_back(typed_row(ACT_START, fccr_pkg::END_OF_CHAIN, 32'd100,
                                  RES_CHAIN_END));
      dir_tab.push_back(typed_row(ACT_START, 16'hFFFF, 32'hFFFF_FFFF, RES_CHAIN_END));
      dir_tab.push_back(typed_row(ACT_START, fccr_pkg::FIRST_CLUSTER, 32'd0,
                                  RES_EMPTY_FILE));
      dir_tab.push_back(item_row(ACT_START, 16'd2, 32'd1000));
      dir_tab.push_back(item_row(ACT_NEXT, 16'd3, 32'd0));
      dir_tab.push_back(item_row(ACT_START, 16'hFFF7, 32'hFFFF_FFFF));
      dir_tab.push_back(typed_row(ACT_NEXT, 16'hFFFF, 32'hFFFF_FFFF, RES_CHAIN_END));
      dir_tab.push_back(typed_row(ACT_NEXT, 16'h0005, 32'd0, RES_IDLE_NEXT));
      dir_tab.push_back(item_row(ACT_START, 16'd100, 32'd600));
      // restart while an entry is pending
      dir_tab.push_back(item_row(ACT_START, 16'd200, 32'd10));
      dir_tab.push_back(typed_row(ACT_NEXT, 16'd7, 32'd0, RES_IDLE_NEXT));
      // zero sectors per cluster: fat requests only
      dir_tab.push_back(cfg_row(fccr_pkg::REG_CLUSTER_SECTORS, 32'd0));
      dir_tab.push_back(item_row(ACT_START, 16'd10, 32'd5000));
      dir_tab.push_back(item_row(ACT_NEXT, 16'h8000, 32'd5000));
      dir_tab.push_back(typed_row(ACT_NEXT, 16'd0, 32'd0, RES_CHAIN_END));
      // largest geometry, lba sums wrap, oversized cluster clamps to 64
      dir_tab.push_back(cfg_row(fccr_pkg::REG_VOLUME_START, 32'hFFFF_FFF0));
      dir_tab.push_back(cfg_row(fccr_pkg::REG_RESERVED_SECTORS, 32'hFFFF));
      dir_tab.push_back(cfg_row(fccr_pkg::REG_FAT_COPIES, 32'd255));
      dir_tab.push_back(cfg_row(fccr_pkg::REG_SECTORS_EACH_FAT, 32'hFFFF));
      dir_tab.push_back(cfg_row(fccr_pkg::REG_ROOT_ENTRIES, 32'hFFFF));
      dir_tab.push_back(cfg_row(fccr_pkg::REG_CLUSTER_SECTORS, 32'd127));
      dir_tab.push_back(item_row(ACT_START, 16'hFFF7, 32'hFFFF_FFFF));
      dir_tab.push_back(item_row(ACT_NEXT, 16'hFFF6, 32'd0));
      dir_tab.push_back(item_row(ACT_START, 16'd2, 32'd32768));
      dir_tab.push_back(item_row(ACT_START, 16'd3, 32'd32769));
      dir_tab.push_back(item_row(ACT_NEXT, 16'd4, 32'd0));

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_tab[i]) begin
         if (dir_tab[i].is_cfg) begin
            wait_drained();
            write_reg(dir_tab[i].reg_idx, dir_tab[i].reg_val);
         end else begin
            send_request(dir_tab[i].action, dir_tab[i].cluster, dir_tab[i].size,
                         dir_tab[i].typed, dir_tab[i].typed_res);
         end
      end

      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin
               send_idle_pct = 16;
               rcv_stall_pct = 85;
            end
            1: begin
               send_idle_pct = 85;
               rcv_stall_pct = 16;
            end
            default: begin
               send_idle_pct = 0;
               rcv_stall_pct = 0;
            end
         endcase
         for (int ph = 0; ph < 2; ph++) begin
            wait_drained();
            random_geometry();
            repeat (ITEMS_PER_PHASE) random_request();
         end
      end

      wait_drained();
      repeat (40) @(posedge clock);
      if (n_errors == 0) begin
         $display("fat16_cluster_chain_reader_unit_test passed");
      end else begin
         $display("fat16_cluster_chain_reader_unit_test failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
